### hdl/nsfc_pkg.sv
// ----------------------------------------------------------------------------
// nsfc_pkg
// Shared constants, sentence kind codes and decode functions for the NMEA
// sentence framer and checksum checker.
// ----------------------------------------------------------------------------
package nsfc_pkg;

	// Default sizing
	localparam int unsigned LINE_CAPACITY_DEF = 128;
	localparam int unsigned MAX_FIELDS_DEF    = 24;

	// Fixed field widths
	localparam int unsigned FIELD_W = 5;
	localparam int unsigned CNT_W   = 32;
	localparam int unsigned IN_W    = 8;
	localparam int unsigned OUT_W   = 112;

	// Framing characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	typedef enum logic [2:0] {
		KIND_OTHER = 3'd0,
		KIND_GGA   = 3'd1,
		KIND_RMC   = 3'd2,
		KIND_GSA   = 3'd3,
		KIND_GSV   = 3'd4,
		KIND_VTG   = 3'd5,
		KIND_GLL   = 3'd6,
		KIND_ZDA   = 3'd7
	} kind_t;

	// Hex digit decode: bit 4 set when the byte is a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	// Map three type characters to a sentence kind
	function automatic kind_t kind_decode(input logic [23:0] t);
		kind_t k;
		unique case (t)
			{8'h47, 8'h47, 8'h41}: k = KIND_GGA;
			{8'h52, 8'h4D, 8'h43}: k = KIND_RMC;
			{8'h47, 8'h53, 8'h41}: k = KIND_GSA;
			{8'h47, 8'h53, 8'h56}: k = KIND_GSV;
			{8'h56, 8'h54, 8'h47}: k = KIND_VTG;
			{8'h47, 8'h4C, 8'h4C}: k = KIND_GLL;
			{8'h5A, 8'h44, 8'h41}: k = KIND_ZDA;
			default:               k = KIND_OTHER;
		endcase
		return k;
	endfunction

	// Minimum field count for a kind's handler
	function automatic logic [FIELD_W-1:0] kind_min_fields(input kind_t k);
		logic [FIELD_W-1:0] n;
		unique case (k)
			KIND_GGA: n = FIELD_W'(12);
			KIND_RMC: n = FIELD_W'(10);
			KIND_GSA: n = FIELD_W'(3);
			KIND_GSV: n = FIELD_W'(0);
			KIND_VTG: n = FIELD_W'(2);
			KIND_GLL: n = FIELD_W'(6);
			KIND_ZDA: n = FIELD_W'(5);
			default:  n = FIELD_W'(0);
		endcase
		return n;
	endfunction

endpackage

### hdl/nmea_sentence_framer_checker.sv
// ----------------------------------------------------------------------------
// nmea_sentence_framer_checker
// Output path: the LF word that ends a line is held in the input register, and
// its result word is written into the result register that drives the output.
// Throughput: one input word per cycle; the input stalls only while a byte
// waits behind a result word that the sink has not taken.
// Reset: arst_n clears the line state, the counters and both valid flags.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_checker #(
	parameter int unsigned LINE_CAPACITY = nsfc_pkg::LINE_CAPACITY_DEF,
	parameter int unsigned MAX_FIELDS    = nsfc_pkg::MAX_FIELDS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// tdata: rx_byte[7:0]
	input  logic [nsfc_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// tdata: checksum_ok[0], sentence_kind[3:1], field_total[8:4],
	// handler_runs[9], lines_seen[41:10], sentences_good[73:42],
	// checksum_failures[105:74], zero pad[111:106]
	output logic [nsfc_pkg::OUT_W-1:0] m_axis_tdata
);

	localparam int unsigned KW = $clog2(LINE_CAPACITY);
	localparam int unsigned FW = nsfc_pkg::FIELD_W;
	localparam int unsigned CW = nsfc_pkg::CNT_W;

	// Input stage
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 adv;

	// Line state
	logic [KW-1:0]        kept_q;
	logic [7:0]           xor_q;
	logic                 star_q;
	logic                 hex_q;
	logic [7:0]           rsum_q;
	logic [23:0]          type_q;
	logic [FW-1:0]        fields_q;
	logic                 open_q;
	logic [CW-1:0]        lines_q;
	logic [CW-1:0]        good_q;
	logic [CW-1:0]        bad_q;

	// Next values
	logic [KW-1:0]        kept_d;
	logic [7:0]           xor_d;
	logic                 star_d;
	logic                 hex_d;
	logic [7:0]           rsum_d;
	logic [23:0]          type_d;
	logic [FW-1:0]        fields_d;
	logic                 open_d;
	logic [CW-1:0]        lines_d;
	logic [CW-1:0]        good_d;
	logic [CW-1:0]        bad_d;
	logic                 res_fire;
	logic                 ok;
	nsfc_pkg::kind_t      kind;
	logic                 runs;

	// Result register
	logic                 out_valid_q;
	logic [nsfc_pkg::OUT_W-1:0] out_data_q;

	// Advance the single stage when the result register can take a word
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	// Hold the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Process one byte against the line state
	always_comb begin
		logic [4:0] hd;
		hd       = nsfc_pkg::hex_digit(byte_s1);
		kept_d   = kept_q;
		xor_d    = xor_q;
		star_d   = star_q;
		hex_d    = hex_q;
		rsum_d   = rsum_q;
		type_d   = type_q;
		fields_d = fields_q;
		open_d   = open_q;
		lines_d  = lines_q;
		good_d   = good_q;
		bad_d    = bad_q;
		res_fire = 1'b0;
		ok       = star_q && (xor_q == rsum_q);
		kind     = (kept_q >= KW'(6)) ? nsfc_pkg::kind_decode(type_q)
		                              : nsfc_pkg::KIND_OTHER;
		runs     = ok && (kind != nsfc_pkg::KIND_OTHER) &&
		           (fields_q >= nsfc_pkg::kind_min_fields(kind));

		if (byte_s1 == nsfc_pkg::CH_CR) begin
			// ignore carriage return
		end else if (byte_s1 == nsfc_pkg::CH_LF) begin
			// Close the line: emit a word when anything was kept
			if (kept_q != '0) begin
				res_fire = 1'b1;
				lines_d  = lines_q + 1'b1;
				if (ok) begin
					good_d = good_q + 1'b1;
				end else begin
					bad_d = bad_q + 1'b1;
				end
			end
			kept_d   = '0;
			xor_d    = '0;
			star_d   = 1'b0;
			hex_d    = 1'b0;
			rsum_d   = '0;
			type_d   = '0;
			fields_d = '0;
			open_d   = 1'b0;
		end else if (kept_q == '0 && byte_s1 != nsfc_pkg::CH_DOLLAR) begin
			// drop bytes before the start mark
		end else if (kept_q < KW'(LINE_CAPACITY - 1)) begin
			// Capture the type characters
			if (kept_q == KW'(3)) type_d[23:16] = byte_s1;
			if (kept_q == KW'(4)) type_d[15:8]  = byte_s1;
			if (kept_q == KW'(5)) type_d[7:0]   = byte_s1;
			if (star_q) begin
				// Shift in received checksum digits
				if (hex_q) begin
					if (!hd[4]) begin
						hex_d = 1'b0;
					end else begin
						rsum_d = {rsum_q[3:0], hd[3:0]};
					end
				end
			end else if (byte_s1 == nsfc_pkg::CH_STAR) begin
				star_d = 1'b1;
				hex_d  = 1'b1;
				rsum_d = '0;
			end else begin
				// Accumulate the sum and count fields
				if (kept_q != '0) begin
					xor_d = xor_q ^ byte_s1;
				end
				if (open_q) begin
					if (byte_s1 == nsfc_pkg::CH_COMMA) open_d = 1'b0;
				end else if (byte_s1 != nsfc_pkg::CH_DOLLAR &&
				             fields_q < FW'(MAX_FIELDS)) begin
					fields_d = fields_q + 1'b1;
					open_d   = (byte_s1 != nsfc_pkg::CH_COMMA);
				end
			end
			kept_d = kept_q + 1'b1;
		end
	end

	// Update line state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q   <= '0;
			xor_q    <= '0;
			star_q   <= 1'b0;
			hex_q    <= 1'b0;
			rsum_q   <= '0;
			type_q   <= '0;
			fields_q <= '0;
			open_q   <= 1'b0;
			lines_q  <= '0;
			good_q   <= '0;
			bad_q    <= '0;
		end else if (adv) begin
			kept_q   <= kept_d;
			xor_q    <= xor_d;
			star_q   <= star_d;
			hex_q    <= hex_d;
			rsum_q   <= rsum_d;
			type_q   <= type_d;
			fields_q <= fields_d;
			open_q   <= open_d;
			lines_q  <= lines_d;
			good_q   <= good_d;
			bad_q    <= bad_d;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_fire;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv && res_fire) begin
			out_data_q <= {6'd0, bad_d, good_d, lines_d, runs, fields_q,
			               kind, ok};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

### hdl/nsfc_checker.sv
// ----------------------------------------------------------------------------
// nsfc_checker
// Port-level checks for the NMEA sentence framer and checksum checker.
// ----------------------------------------------------------------------------
module nsfc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [111:0] m_axis_tdata
);

	// Hold a stalled output word
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// Line count is the sum of good and failed sentences
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[41:10] ==
		(m_axis_tdata[73:42] + m_axis_tdata[105:74]))
		else $error("line counter out of step with good and bad counters");

	// Handler runs only with a good checksum and a known kind
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[9] |->
		m_axis_tdata[0] && (m_axis_tdata[3:1] != 3'd0))
		else $error("handler flagged without good checksum or kind");

	// Padding stays zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[111:106] == 6'd0)
		else $error("output padding not zero");

endmodule

bind nmea_sentence_framer_checker nsfc_checker u_nsfc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
